@@ hw/rtl/ravg_pkg.sv @@
// Shared types, constants and a helper function for the 3x3 region average smoother.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ravg_pkg;

  // floor(x / 9) for x < 4096 equals (x * ceil(2^16 / 9)) >> 16.
  localparam int unsigned AreaRecip  = 7282;
  localparam int unsigned RecipShift = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  ThresholdRst = 8'd10;
  localparam logic [9:0]  WidthRst     = 10'd512;
  localparam logic [11:0] HeightRst    = 12'd512;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_TOP,
    ST_RD_MID,
    ST_CAP_MID,
    ST_EVAL,
    ST_ACCUM,
    ST_DIV,
    ST_EMIT,
    ST_ADV,
    ST_D_RD,
    ST_D_CAP
  } state_e;

  // One accumulator entry: running region sum and hit count.
  typedef struct packed {
    logic [11:0] sum;
    logic [3:0]  cnt;
  } acc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_item;
    logic       rd_top;
    logic       rd_mid;
    logic       cap_mid;
    logic       eval;
    logic       accum;
    logic       rd_drain;
    logic       cap_drain;
    logic       div;
    logic       wb_mid;
    logic       wb_bot;
    logic       emit;
    logic       run_last;
    logic       adv_pixel;
    logic       adv_drain;
    logic       end_image;
    logic [1:0] sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic row_ge_h;
    logic drain_over;
    logic row_ge2;
    logic col_ge2;
    logic row_end;
    logic out_free;
  } status_t;

  // ceil(2^16 / n): floor(s / n) = (s * recip(n)) >> 16 for s < 4096.
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ravg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ravg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ravg_ctrl.sv @@
// Sequencing state machine of the region average smoother.
// Depends on ravg_pkg for the state enum and the command/status structs.
module ravg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output ravg_pkg::cmd_t    cmd_o,
  input  ravg_pkg::status_t sts_i
);

  ravg_pkg::state_e state_q, state_d;
  logic [1:0] k_q;
  logic [1:0] last_q;
  logic       emit_q;
  logic       wb_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ravg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ravg_pkg::ST_CHECK;
      end
      ravg_pkg::ST_CHECK: begin
        if (sts_i.mode) begin
          if (!sts_i.row_ge_h || sts_i.drain_over) state_d = ravg_pkg::ST_IDLE;
          else state_d = ravg_pkg::ST_D_RD;
        end else begin
          if (sts_i.row_ge_h) state_d = ravg_pkg::ST_IDLE;
          else state_d = ravg_pkg::ST_RD_TOP;
        end
      end
      ravg_pkg::ST_RD_TOP:  state_d = ravg_pkg::ST_RD_MID;
      ravg_pkg::ST_RD_MID:  state_d = ravg_pkg::ST_CAP_MID;
      ravg_pkg::ST_CAP_MID: state_d = ravg_pkg::ST_EVAL;
      ravg_pkg::ST_EVAL:    state_d = ravg_pkg::ST_ACCUM;
      ravg_pkg::ST_ACCUM: begin
        state_d = sts_i.col_ge2 ? ravg_pkg::ST_DIV : ravg_pkg::ST_ADV;
      end
      ravg_pkg::ST_D_RD:  state_d = ravg_pkg::ST_D_CAP;
      ravg_pkg::ST_D_CAP: state_d = ravg_pkg::ST_DIV;
      ravg_pkg::ST_DIV:   state_d = ravg_pkg::ST_EMIT;
      ravg_pkg::ST_EMIT: begin
        if (!emit_q || sts_i.out_free) begin
          state_d = (k_q == last_q) ? ravg_pkg::ST_ADV : ravg_pkg::ST_DIV;
        end
      end
      ravg_pkg::ST_ADV: state_d = ravg_pkg::ST_IDLE;
      default:          state_d = ravg_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = k_q;
    in_ready_o = 1'b0;
    case (state_q)
      ravg_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch_item = in_valid_i;
      end
      ravg_pkg::ST_CHECK: begin
        cmd_o.end_image = sts_i.mode && sts_i.row_ge_h && sts_i.drain_over;
      end
      ravg_pkg::ST_RD_TOP:  cmd_o.rd_top = 1'b1;
      ravg_pkg::ST_RD_MID:  cmd_o.rd_mid = 1'b1;
      ravg_pkg::ST_CAP_MID: cmd_o.cap_mid = 1'b1;
      ravg_pkg::ST_EVAL:    cmd_o.eval = 1'b1;
      ravg_pkg::ST_ACCUM:   cmd_o.accum = 1'b1;
      ravg_pkg::ST_D_RD:    cmd_o.rd_drain = 1'b1;
      ravg_pkg::ST_D_CAP:   cmd_o.cap_drain = 1'b1;
      ravg_pkg::ST_DIV: begin
        cmd_o.div    = 1'b1;
        cmd_o.wb_mid = wb_q;
      end
      ravg_pkg::ST_EMIT: begin
        cmd_o.wb_bot   = wb_q;
        cmd_o.emit     = emit_q && sts_i.out_free;
        cmd_o.run_last = (k_q == last_q);
      end
      ravg_pkg::ST_ADV: begin
        cmd_o.adv_pixel = !sts_i.mode;
        cmd_o.adv_drain = sts_i.mode;
      end
      default: cmd_o = '0;
    endcase
  end

  // State register and the per-item result loop counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ravg_pkg::ST_IDLE;
      k_q     <= 2'd0;
      last_q  <= 2'd0;
      emit_q  <= 1'b0;
      wb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ravg_pkg::ST_ACCUM) begin
        k_q    <= 2'd0;
        last_q <= sts_i.row_end ? 2'd2 : 2'd0;
        emit_q <= sts_i.row_ge2;
        wb_q   <= 1'b1;
      end else if (state_q == ravg_pkg::ST_D_CAP) begin
        k_q    <= 2'd0;
        last_q <= 2'd0;
        emit_q <= 1'b1;
        wb_q   <= 1'b0;
      end else if (state_q == ravg_pkg::ST_EMIT && state_d == ravg_pkg::ST_DIV) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/ravg_dp.sv @@
// Datapath of the region average smoother: positions, 3x3 windows, line memories,
// region test, accumulation, reciprocal divide and output register.
// Depends on ravg_pkg and ravg_ram.
module ravg_dp #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              in_mode_i,
  input  logic [7:0]        in_pixel_i,
  input  ravg_pkg::cmd_t    cmd_i,
  output ravg_pkg::status_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_value_o,
  output logic              out_run_last_o,
  output logic              out_image_last_o
);

  localparam int unsigned CLW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW    = $clog2(2 * MAX_WIDTH + 1);
  localparam int unsigned DEPTH = 3 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [7:0]  cfg_thr_q;
  logic [9:0]  cfg_width_q;
  logic [11:0] cfg_height_q;

  // Positions and row slots.
  logic [11:0]    row_q;
  logic [CLW-1:0] col_q;
  logic [DW-1:0]  drain_q;
  logic [1:0]     sbot_q;
  logic [WW-1:0]  hw_q [3];

  // Current item.
  logic       mode_q;
  logic [7:0] pix_q;

  // Windows: row 0 is the oldest row, column 2 is the newest column.
  logic [7:0]     pw_q [3][3];
  ravg_pkg::acc_t aw_q [3][3];

  logic        ok_q;
  logic [11:0] sum9_q;
  logic [28:0] prod_q;
  logic        cnt_zero_q;
  logic [7:0]  fpix_q;

  logic       out_valid_q;
  logic [7:0] out_value_q;
  logic       out_last_q;
  logic       out_img_q;

  logic [WW-1:0]  eff_w;
  logic [11:0]    eff_h;
  logic [1:0]     stop, smid;
  logic [DW-1:0]  total;
  logic [DW:0]    drain_nx;
  logic           drain_last;
  logic           drain_hi;
  logic [CLW-1:0] dcol;
  logic [1:0]     dslot;
  logic [CLW-1:0] wb_col;
  logic [WW-1:0]  col_nx;
  logic           row_end;

  logic          ram_re;
  logic [AW-1:0] raddr;
  logic          acc_we;
  logic [AW-1:0] acc_waddr;
  logic [15:0]   acc_wdata;
  logic [15:0]   acc_rdata;
  logic [7:0]    pix_rdata;

  logic          ok_c;
  logic [11:0]   sum9_c;
  logic [24:0]   avg_prod;
  logic [7:0]    avg;
  ravg_pkg::acc_t sel_acc;

  function automatic logic [AW-1:0] addr_of(input logic [1:0] slot, input logic [CLW-1:0] col);
    return AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  function automatic logic too_far(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] t);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > t;
  endfunction

  // Effective geometry and derived positions.
  always_comb begin
    if (cfg_width_q < 10'd3) eff_w = WW'(3);
    else if (32'(cfg_width_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(cfg_width_q);
    eff_h = (cfg_height_q < 12'd3) ? 12'd3 : cfg_height_q;
  end

  assign stop       = (sbot_q == 2'd2) ? 2'd0 : sbot_q + 2'd1;
  assign smid       = (sbot_q == 2'd0) ? 2'd2 : sbot_q - 2'd1;
  assign total      = DW'({eff_w, 1'b0});
  assign drain_nx   = {1'b0, drain_q} + {{DW{1'b0}}, 1'b1};
  assign drain_last = drain_nx >= {1'b0, total};
  assign drain_hi   = drain_q >= DW'(eff_w);
  assign dcol       = drain_hi ? CLW'(drain_q - DW'(eff_w)) : CLW'(drain_q);
  assign dslot      = drain_hi ? smid : stop;
  assign wb_col     = col_q - CLW'(2) + CLW'(cmd_i.sel);
  assign col_nx     = WW'(col_q) + WW'(1);
  assign row_end    = col_nx >= eff_w;

  // Status to the controller.
  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.row_ge_h   = row_q >= eff_h;
    sts_o.drain_over = drain_q >= total;
    sts_o.row_ge2    = row_q >= 12'd2;
    sts_o.col_ge2    = col_q >= CLW'(2);
    sts_o.row_end    = row_end;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Memory addressing: one shared read address, accumulator write-back of two rows.
  always_comb begin
    ram_re = cmd_i.rd_top || cmd_i.rd_mid || cmd_i.rd_drain;
    if (cmd_i.rd_top) raddr = addr_of(stop, col_q);
    else if (cmd_i.rd_mid) raddr = addr_of(smid, col_q);
    else raddr = addr_of(dslot, dcol);
    acc_we    = cmd_i.wb_mid || cmd_i.wb_bot;
    acc_waddr = addr_of(cmd_i.wb_mid ? smid : sbot_q, wb_col);
    acc_wdata = cmd_i.wb_mid ? aw_q[1][cmd_i.sel] : aw_q[2][cmd_i.sel];
  end

  ravg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rd_top),
    .waddr_i (addr_of(sbot_q, col_q)),
    .wdata_i (pix_q),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (pix_rdata)
  );

  ravg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (acc_rdata)
  );

  // Region test and window sum over the 3x3 pixel window.
  always_comb begin
    ok_c   = (row_q >= 12'd2) && (col_q >= CLW'(2));
    sum9_c = 12'd0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        sum9_c = sum9_c + 12'(pw_q[a][b]);
        if (b < 2 && too_far(pw_q[a][b], pw_q[a][b+1], cfg_thr_q)) ok_c = 1'b0;
        if (a < 2 && too_far(pw_q[a][b], pw_q[a+1][b], cfg_thr_q)) ok_c = 1'b0;
      end
    end
  end

  assign avg_prod = 25'(sum9_q) * 25'(ravg_pkg::AreaRecip);
  assign avg      = avg_prod[ravg_pkg::RecipShift +: 8];
  assign sel_acc  = aw_q[0][cmd_i.sel];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q    <= ravg_pkg::ThresholdRst;
      cfg_width_q  <= ravg_pkg::WidthRst;
      cfg_height_q <= ravg_pkg::HeightRst;
    end else if (cfg_we_i) begin
      case (ravg_pkg::cfg_reg_e'(cfg_idx_i))
        ravg_pkg::REG_THRESHOLD: cfg_thr_q    <= cfg_data_i[7:0];
        ravg_pkg::REG_WIDTH:     cfg_width_q  <= cfg_data_i[9:0];
        ravg_pkg::REG_HEIGHT:    cfg_height_q <= cfg_data_i;
        default:                 cfg_thr_q    <= cfg_thr_q;
      endcase
    end
  end

  // Positions, row slots and per-slot initialized-column marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= 12'd0;
      col_q   <= '0;
      drain_q <= '0;
      sbot_q  <= 2'd0;
      mode_q  <= 1'b0;
      for (int s = 0; s < 3; s++) hw_q[s] <= '0;
    end else begin
      if (cmd_i.latch_item) mode_q <= in_mode_i;
      if (cmd_i.rd_top && col_q == '0) hw_q[sbot_q] <= '0;
      if (cmd_i.cap_mid) begin
        for (int s = 0; s < 3; s++) begin
          if (hw_q[s] < col_nx) hw_q[s] <= col_nx;
        end
      end
      if (cmd_i.adv_pixel) begin
        if (row_end) begin
          col_q  <= '0;
          row_q  <= row_q + 12'd1;
          sbot_q <= stop;
        end else begin
          col_q <= col_q + CLW'(1);
        end
      end
      if (cmd_i.end_image || (cmd_i.adv_drain && drain_last)) begin
        row_q   <= 12'd0;
        col_q   <= '0;
        drain_q <= '0;
        sbot_q  <= 2'd0;
      end else if (cmd_i.adv_drain) begin
        drain_q <= drain_nx[DW-1:0];
      end
    end
  end

  // Window registers, region result and divider product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) pix_q <= in_pixel_i;
    if (cmd_i.rd_top) begin
      for (int a = 0; a < 3; a++) begin
        pw_q[a][0] <= pw_q[a][1];
        pw_q[a][1] <= pw_q[a][2];
        aw_q[a][0] <= aw_q[a][1];
        aw_q[a][1] <= aw_q[a][2];
      end
      pw_q[2][2] <= pix_q;
      aw_q[2][2] <= '0;
    end
    if (cmd_i.rd_mid) begin
      pw_q[0][2] <= pix_rdata;
      aw_q[0][2] <= (WW'(col_q) >= hw_q[stop]) ? '0 : acc_rdata;
    end
    if (cmd_i.cap_mid) begin
      pw_q[1][2] <= pix_rdata;
      aw_q[1][2] <= (WW'(col_q) >= hw_q[smid]) ? '0 : acc_rdata;
    end
    if (cmd_i.cap_drain) begin
      pw_q[0][0] <= pix_rdata;
      aw_q[0][0] <= (WW'(dcol) >= hw_q[dslot]) ? '0 : acc_rdata;
    end
    if (cmd_i.eval) begin
      ok_q   <= ok_c;
      sum9_q <= sum9_c;
    end
    if (cmd_i.accum && ok_q) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          aw_q[a][b].sum <= aw_q[a][b].sum + 12'(avg);
          aw_q[a][b].cnt <= aw_q[a][b].cnt + 4'd1;
        end
      end
    end
    if (cmd_i.div) begin
      prod_q     <= 29'(sel_acc.sum) * 29'(ravg_pkg::recip(sel_acc.cnt));
      cnt_zero_q <= sel_acc.cnt == 4'd0;
      fpix_q     <= pw_q[0][cmd_i.sel];
    end
  end

  // Output register: holds one beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= cnt_zero_q ? fpix_q : prod_q[ravg_pkg::RecipShift +: 8];
      out_last_q  <= cmd_i.run_last;
      out_img_q   <= mode_q && drain_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_value_o      = out_value_q;
  assign out_run_last_o   = out_last_q;
  assign out_image_last_o = out_img_q;

endmodule

@@ hw/rtl/region_average_smoothing_3x3_core.sv @@
// Pixel item: reads, region test, accumulation, a divide and emit per finished column
// (one, or three at a row end), plus output waits; drain item: read, divide, emit.
// The rate is set by the single read and write port of each line memory and the
// shared reciprocal multiplier. Results leave through a one-beat output register.
// Reset (rst_ni low, asynchronous) clears positions, state and configuration registers
// to defaults; no memory clearing pass is needed.
module region_average_smoothing_3x3_core #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] pixel
  input  logic        s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] value
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // [0] image_last
);

  ravg_pkg::cmd_t    cmd;
  ravg_pkg::status_t sts;

  ravg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ravg_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_mode_i        (s_axis_tuser),
    .in_pixel_i       (s_axis_tdata),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_value_o      (m_axis_tdata),
    .out_run_last_o   (m_axis_tlast),
    .out_image_last_o (m_axis_tuser)
  );

endmodule

@@ hw/rtl/ravg_chk.sv @@
// Port-level checker for the region average smoother, bound to the top level.
// Depends only on the top level's ports.
module ravg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [11:0] cfg_data_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A stalled output beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // The final pixel of an image is always the last result of its item.
  a_img_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("image end without run end");

  // Input ready always drops after an accepted item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind region_average_smoothing_3x3_core ravg_chk u_ravg_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 region average smoother.
// Depends on ravg_pkg and region_average_smoothing_3x3_core; predicts every beat in-line.
module tb_top;

  localparam int unsigned MaxW      = 512;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       image_last;
  } pix_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = ravg_pkg::REG_THRESHOLD;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] pixel
  logic        s_axis_tuser = 1'b0;  // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [7:0] value
  logic        m_axis_tlast;
  logic        m_axis_tuser;  // [0] image_last

  region_average_smoothing_3x3_core #(.MAX_WIDTH(MaxW)) DUT (.*);

  // Predictor state: line stores, accumulators, positions and registers.
  logic [7:0]  line_pix [3*MaxW];
  logic [11:0] acc_sum  [3*MaxW];
  logic [3:0]  acc_cnt  [3*MaxW];
  int unsigned cur_row, cur_col, drain_idx;
  int unsigned thr_reg, width_reg, height_reg;

  pix_out_t smoothed_q[$];
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          send_quiet = 1'b0;
  int unsigned rx_hold = 0;
  int          walk_val = 128;

  // Clock and watchdog.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    if (width_reg < 3) return 3;
    if (width_reg > MaxW) return MaxW;
    return width_reg;
  endfunction

  function automatic int unsigned idx(int unsigned slot, int unsigned col);
    return (slot % 3) * MaxW + (col % MaxW);
  endfunction

  function automatic logic [7:0] final_value(int unsigned slot, int unsigned col);
    int unsigned i;
    i = idx(slot, col);
    if (acc_cnt[i] != 0) return 8'(acc_sum[i] / acc_cnt[i]);
    return line_pix[i];
  endfunction

  function automatic int unsigned adiff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Works out the beats one accepted input causes and queues them.
  task automatic smooth_predict(input logic mode, input logic [7:0] pix);
    int unsigned w, h, r, c, sr, sum, v, k;
    bit ok;
    pix_out_t res [$];
    int unsigned sl [3];
    w = eff_w();
    h = (height_reg < 3) ? 3 : height_reg;
    if (!mode) begin
      r = cur_row;
      c = cur_col % MaxW;
      sr = r % 3;
      if (r >= h) return;
      if (c == 0) begin
        for (int unsigned j = 0; j < MaxW; j++) begin
          acc_sum[idx(sr, j)] = '0;
          acc_cnt[idx(sr, j)] = '0;
        end
      end
      line_pix[idx(sr, c)] = pix;
      if (r >= 2 && c >= 2) begin
        sl[0] = (r - 2) % 3;
        sl[1] = (r - 1) % 3;
        sl[2] = sr;
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            v = line_pix[idx(sl[a], c - 2 + b)];
            if (b < 2 && adiff(v, line_pix[idx(sl[a], c - 1 + b)]) > thr_reg) ok = 1'b0;
            if (a < 2 && adiff(v, line_pix[idx(sl[a+1], c - 2 + b)]) > thr_reg) ok = 1'b0;
          end
        end
        if (ok) begin
          sum = 0;
          for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) sum += line_pix[idx(sl[a], c - 2 + b)];
          sum = sum / 9;
          for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
              k = idx(sl[a], c - 2 + b);
              acc_sum[k] = 12'(acc_sum[k] + sum);
              acc_cnt[k] = 4'(acc_cnt[k] + 1);
            end
          end
        end
        res.push_back('{final_value(sl[0], c - 2), 1'b0, 1'b0});
        if (c + 1 >= w) begin
          res.push_back('{final_value(sl[0], c - 1), 1'b0, 1'b0});
          res.push_back('{final_value(sl[0], c), 1'b0, 1'b0});
        end
      end
      if (c + 1 >= w) begin
        cur_col = 0;
        cur_row = r + 1;
      end else begin
        cur_col = c + 1;
      end
    end else begin
      k = drain_idx;
      if (cur_row < h) return;
      if (k >= 2 * w) begin
        cur_row = 0;
        cur_col = 0;
        drain_idx = 0;
        return;
      end
      res.push_back('{final_value((cur_row - 2 + k / w) % 3, k % w), 1'b0,
                      (k + 1 >= 2 * w)});
      if (k + 1 >= 2 * w) begin
        cur_row = 0;
        cur_col = 0;
        drain_idx = 0;
      end else begin
        drain_idx = k + 1;
      end
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) smoothed_q.push_back(res[i]);
  endtask

  // Result checker: each beat against the oldest expectation.
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10) $display("Unexpected beat: value %0d", m_axis_tdata);
      end else begin
        want = smoothed_q.pop_front();
        if (want.value !== m_axis_tdata || want.run_last !== m_axis_tlast ||
            want.image_last !== m_axis_tuser) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("Mismatch: expected value %0d last %b img %b, got %0d %b %b",
                     want.value, want.run_last, want.image_last,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Receiver: random back-pressure (none while sending quietly), or a long hold when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= send_quiet || ($urandom_range(0, 99) >= 37);
    end
  end

  // Sends one beat, at times with a random gap ahead of it unless sending quietly.
  task automatic send_beat(input logic mode, input logic [7:0] pix);
    @(negedge clk_i);
    if (!send_quiet && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    smooth_predict(mode, pix);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input ravg_pkg::cfg_reg_e which, input logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_data_i <= val;
    case (which)
      ravg_pkg::REG_THRESHOLD: thr_reg = val[7:0];
      ravg_pkg::REG_WIDTH:     width_reg = val[9:0];
      default:                 height_reg = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly smooth content so that regions form; sometimes fully random.
  function automatic logic [7:0] next_pixel(input bit wild);
    if (wild) return 8'($urandom_range(0, 255));
    walk_val = walk_val + int'($urandom_range(0, 8)) - 4;
    if (walk_val < 0) walk_val = 0;
    if (walk_val > 255) walk_val = 255;
    return 8'(walk_val);
  endfunction

  task automatic send_image(input int unsigned w, input int unsigned h, input bit wild);
    for (int unsigned i = 0; i < w * h; i++) send_beat(1'b0, next_pixel(wild));
    for (int unsigned i = 0; i < 2 * w; i++) send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Smallest image, extreme thresholds and pixels, out-of-place items.
  task automatic test_extremes();
    write_reg(ravg_pkg::REG_THRESHOLD, 12'd0);
    write_reg(ravg_pkg::REG_WIDTH, 12'd0);
    write_reg(ravg_pkg::REG_HEIGHT, 12'd0);
    send_beat(1'b1, 8'hFF);  // drain while not draining
    for (int i = 0; i < 9; i++) send_beat(1'b0, (i == 4) ? 8'hFF : 8'h00);
    send_beat(1'b0, 8'h55);  // pixel while draining
    for (int i = 0; i < 6; i++) send_beat(1'b1, 8'h00);
    wait_idle();
    write_reg(ravg_pkg::REG_THRESHOLD, 12'd255);
    for (int i = 0; i < 9; i++) send_beat(1'b0, (i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 6; i++) send_beat(1'b1, 8'hAA);
    wait_idle();
  endtask

  // One image sent without gaps while the receiver holds off for a long stretch.
  task automatic test_long_hold();
    write_reg(ravg_pkg::REG_WIDTH, 12'd10);
    write_reg(ravg_pkg::REG_HEIGHT, 12'd3);
    write_reg(ravg_pkg::REG_THRESHOLD, 12'd12);
    send_quiet = 1'b1;
    for (int unsigned i = 0; i < 30; i++) begin
      if (i == 22) rx_hold = 300;
      send_beat(1'b0, next_pixel(1'b0));
    end
    for (int unsigned i = 0; i < 20; i++) send_beat(1'b1, 8'h00);
    send_quiet = 1'b0;
    wait_idle();
  endtask

  // Tallest setting, then height and width lowered mid-image.
  task automatic test_geometry_change();
    write_reg(ravg_pkg::REG_HEIGHT, 12'd4095);
    write_reg(ravg_pkg::REG_WIDTH, 12'd4);
    write_reg(ravg_pkg::REG_THRESHOLD, 12'd20);
    for (int i = 0; i < 20; i++) send_beat(1'b0, next_pixel(1'b0));
    wait_idle();
    write_reg(ravg_pkg::REG_HEIGHT, 12'd3);
    for (int i = 0; i < 7; i++) send_beat(1'b1, 8'h00);
    wait_idle();
    write_reg(ravg_pkg::REG_WIDTH, 12'd3);
    send_beat(1'b1, 8'h00);  // drain already past its end
    wait_idle();
  endtask

  // Random images with small sizes, plus stray items.
  task automatic test_random_images();
    int unsigned sent;
    int unsigned w, h;
    sent = 0;
    while (sent < 120) begin
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 5);
      write_reg(ravg_pkg::REG_WIDTH, 12'(w));
      write_reg(ravg_pkg::REG_HEIGHT, 12'(h));
      write_reg(ravg_pkg::REG_THRESHOLD,
                ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 255))
                                            : 12'($urandom_range(0, 12)));
      send_quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) send_beat(1'b1, 8'($urandom_range(0, 255)));
      send_image(w, h, ($urandom_range(0, 4) == 0));
      sent += w * h + 2 * w;
      send_quiet = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    cur_row = 0;
    cur_col = 0;
    drain_idx = 0;
    thr_reg = ravg_pkg::ThresholdRst;
    width_reg = ravg_pkg::WidthRst;
    height_reg = ravg_pkg::HeightRst;
    for (int i = 0; i < 3 * MaxW; i++) begin
      line_pix[i] = '0;
      acc_sum[i] = '0;
      acc_cnt[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_long_hold();
    test_geometry_change();
    test_random_images();
    wait_idle();
    if (error_cnt == 0 && smoothed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ravg_pkg.sv
hw/rtl/ravg_ram.sv
hw/rtl/ravg_ctrl.sv
hw/rtl/ravg_dp.sv
hw/rtl/region_average_smoothing_3x3_core.sv
hw/rtl/ravg_chk.sv
tb/tb_top.sv
